### hdl/edpc_pkg.sv
// Shared widths, payload types and lane codes for the disk pair collision pipeline.
`timescale 1ns / 1ps
package edpc_pkg;

  // Field widths.
  localparam int VW  = 32;           // positions and velocities
  localparam int MW  = 16;           // masses
  localparam int RW  = 24;           // radii

  // Internal widths.
  localparam int DFW = VW + 1;       // coordinate differences
  localparam int AW  = RW + 1;       // radius sum, and offsets while near
  localparam int SQW = 2 * AW;       // one squared term
  localparam int DDW = SQW + 1;      // squared distance
  localparam int MSW = MW + 1;       // mass sum
  localparam int DW  = DDW + MSW;    // divisor
  localparam int PW  = DFW + AW + 1; // one term of the dot product
  localparam int SW  = PW + 1;       // dot product
  localparam int LOW = 32;           // split point of wide multiplies
  localparam int MGW = SW + AW;      // dot product times one offset
  localparam int NW  = MGW + MW + 1; // dividend, including the factor two
  localparam int QW  = 36;           // quotient bits, one per divider stage
  localparam int SUMW = QW + 3;      // velocity plus signed correction

  localparam int NLANES       = 4;
  localparam int FRONT_STAGES = 9;
  localparam int BACK_STAGES  = 2;

  // Divider lanes.
  localparam int LANE_FX = 0;
  localparam int LANE_SX = 1;
  localparam int LANE_FY = 2;
  localparam int LANE_SY = 3;

  localparam logic signed [SUMW-1:0] SUM_MAX = $signed(SUMW'({1'b0, {(VW-1){1'b1}}}));
  localparam logic signed [SUMW-1:0] SUM_MIN = ~SUM_MAX;

  typedef struct packed {
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
    logic signed [VW-1:0] v2x;
    logic signed [VW-1:0] v2y;
  } vel_t;

  typedef struct packed {
    logic signed [VW-1:0] p1x;
    logic signed [VW-1:0] p1y;
    logic [MW-1:0]        m1;
    logic [RW-1:0]        r1;
    logic signed [VW-1:0] p2x;
    logic signed [VW-1:0] p2y;
    logic [MW-1:0]        m2;
    logic [RW-1:0]        r2;
    vel_t                 vel;
  } pair_t;

  typedef struct packed {
    vel_t              vel;
    logic              contact;
    logic              go;
    logic [NLANES-1:0] neg;
  } side_t;

  typedef struct packed {
    logic [DW-1:0]                 den;
    logic [NLANES-1:0][DW-1:0]     rem;
    logic [NLANES-1:0][QW-1:0]     lq;
    side_t                         side;
  } quo_t;

  typedef struct packed {
    logic [NLANES-1:0][QW:0] q;
    side_t                   side;
  } rnd_t;

  typedef struct packed {
    logic contact;
    vel_t vel;
  } res_t;

endpackage

### hdl/elastic_disk_pair_collision_unit.sv
// Top level of the elastic collision unit for one pair of disks.
`timescale 1ns / 1ps
// Usage: each input item is one pair of disks (Q16.16 positions and velocities,
// Q8.8 masses, Q8.16 radii). Each item yields exactly one result item: a contact
// flag and both new velocities, in order. Both channels use valid and stall; an
// item moves at a rising edge where valid is high and stall is low.
// The pipeline has 9 front stages (differences, contact test, dot product,
// divisor, dividends), 36 divider stages that each resolve one quotient bit in
// four lanes, and 2 back stages (rounding, saturation, output register).
// Throughput is one item per clock while the output is not stalled; each stage is
// limited by one multiplier or one wide compare and subtract.
// Each stage has its own valid bit and takes a new item when it is empty or when
// its successor moves, so bubbles close up. When the receiver stalls, the output
// holds its item while the stages behind it keep filling; in_stall rises only
// when every stage holds an item.
// A synchronous reset (rst_n low) empties the whole pipeline; payload registers
// are not reset. There is no configuration and no other state.
module elastic_disk_pair_collision_unit
  import edpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [VW-1:0] in_first_pos_x,
  input  logic signed [VW-1:0] in_first_pos_y,
  input  logic signed [VW-1:0] in_first_vel_x,
  input  logic signed [VW-1:0] in_first_vel_y,
  input  logic [MW-1:0]        in_first_mass,
  input  logic [RW-1:0]        in_first_radius,
  input  logic signed [VW-1:0] in_second_pos_x,
  input  logic signed [VW-1:0] in_second_pos_y,
  input  logic signed [VW-1:0] in_second_vel_x,
  input  logic signed [VW-1:0] in_second_vel_y,
  input  logic [MW-1:0]        in_second_mass,
  input  logic [RW-1:0]        in_second_radius,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_in_contact,
  output logic signed [VW-1:0] out_first_new_vel_x,
  output logic signed [VW-1:0] out_first_new_vel_y,
  output logic signed [VW-1:0] out_second_new_vel_x,
  output logic signed [VW-1:0] out_second_new_vel_y
);

  pair_t pair;

  always_comb begin
    pair.p1x     = in_first_pos_x;
    pair.p1y     = in_first_pos_y;
    pair.m1      = in_first_mass;
    pair.r1      = in_first_radius;
    pair.p2x     = in_second_pos_x;
    pair.p2y     = in_second_pos_y;
    pair.m2      = in_second_mass;
    pair.r2      = in_second_radius;
    pair.vel.v1x = in_first_vel_x;
    pair.vel.v1y = in_first_vel_y;
    pair.vel.v2x = in_second_vel_x;
    pair.vel.v2y = in_second_vel_y;
  end

  // Divider chain: index 0 is the front's output, index QW feeds the back end.
  quo_t      quo [QW+1];
  logic [QW:0] qvld;
  logic [QW:0] qrdy;
  logic        front_rdy;
  res_t        res;

  edpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_rdy  (front_rdy),
    .up_data (pair),
    .dn_vld  (qvld[0]),
    .dn_rdy  (qrdy[0]),
    .dn_data (quo[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    edpc_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (qvld[k]),
      .up_rdy  (qrdy[k]),
      .up_data (quo[k]),
      .dn_vld  (qvld[k+1]),
      .dn_rdy  (qrdy[k+1]),
      .dn_data (quo[k+1])
    );
  end

  edpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (qvld[QW]),
    .up_rdy  (qrdy[QW]),
    .up_data (quo[QW]),
    .dn_vld  (out_valid),
    .dn_rdy  (!out_stall),
    .dn_data (res)
  );

  assign in_stall             = !front_rdy;
  assign out_in_contact       = res.contact;
  assign out_first_new_vel_x  = res.vel.v1x;
  assign out_first_new_vel_y  = res.vel.v1y;
  assign out_second_new_vel_x = res.vel.v2x;
  assign out_second_new_vel_y = res.vel.v2y;

  // The pipeline comes out of reset empty.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Backpressure reaches the input only through a stalled, full output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output can move");

  // A pair only gets its velocities updated when it is in contact.
  assert property (@(posedge clk) disable iff (!rst_n)
    (qvld[QW] && quo[QW].side.go) |-> quo[QW].side.contact)
    else $error("velocity update without contact");

  // After the last division step every remainder is below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (qvld[QW] && quo[QW].side.go) |->
      ((quo[QW].rem[LANE_FX] < quo[QW].den) && (quo[QW].rem[LANE_SX] < quo[QW].den) &&
       (quo[QW].rem[LANE_FY] < quo[QW].den) && (quo[QW].rem[LANE_SY] < quo[QW].den)))
    else $error("division remainder out of range");

endmodule

### hdl/edpc_front.sv
// Front pipeline: contact test, dot product, divisor and dividends for four lanes.
`timescale 1ns / 1ps
module edpc_front
  import edpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_vld,
  output logic  up_rdy,
  input  pair_t up_data,
  output logic  dn_vld,
  input  logic  dn_rdy,
  output quo_t  dn_data
);

  logic [FRONT_STAGES-1:0] vld_r;
  logic [FRONT_STAGES-1:0] vld_in;
  logic [FRONT_STAGES:0]   rdy;

  always_comb begin
    rdy[FRONT_STAGES] = dn_rdy;
    for (int i = FRONT_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vld_in = {vld_r[FRONT_STAGES-2:0], up_vld};
  assign up_rdy = rdy[0];
  assign dn_vld = vld_r[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < FRONT_STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_in[i];
        end
      end
    end
  end

  // Stage 1: differences and sums.
  logic signed [DFW-1:0] dx1_r, dy1_r, wx1_r, wy1_r;
  logic [AW-1:0]         rs1_r;
  logic [MW-1:0]         m1_1_r, m2_1_r;
  logic [MSW-1:0]        ms1_r;
  vel_t                  vel1_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx1_r  <= DFW'(up_data.p2x) - DFW'(up_data.p1x);
      dy1_r  <= DFW'(up_data.p2y) - DFW'(up_data.p1y);
      wx1_r  <= DFW'(up_data.vel.v1x) - DFW'(up_data.vel.v2x);
      wy1_r  <= DFW'(up_data.vel.v1y) - DFW'(up_data.vel.v2y);
      rs1_r  <= AW'(up_data.r1) + AW'(up_data.r2);
      m1_1_r <= up_data.m1;
      m2_1_r <= up_data.m2;
      ms1_r  <= MSW'(up_data.m1) + MSW'(up_data.m2);
      vel1_r <= up_data.vel;
    end
  end

  // Stage 2: magnitudes and the box test.
  logic [DFW-1:0]        adx_nxt, ady_nxt;
  logic [AW-1:0]         ax2_r, ay2_r, rs2_r;
  logic                  near2_r, dxn2_r, dyn2_r;
  logic signed [AW:0]    dxs2_r, dys2_r;
  logic signed [DFW-1:0] wx2_r, wy2_r;
  logic [MW-1:0]         m1_2_r, m2_2_r;
  logic [MSW-1:0]        ms2_r;
  vel_t                  vel2_r;

  assign adx_nxt = dx1_r[DFW-1] ? DFW'(-dx1_r) : DFW'(dx1_r);
  assign ady_nxt = dy1_r[DFW-1] ? DFW'(-dy1_r) : DFW'(dy1_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ax2_r   <= adx_nxt[AW-1:0];
      ay2_r   <= ady_nxt[AW-1:0];
      near2_r <= (adx_nxt <= DFW'(rs1_r)) && (ady_nxt <= DFW'(rs1_r));
      dxn2_r  <= dx1_r[DFW-1];
      dyn2_r  <= dy1_r[DFW-1];
      dxs2_r  <= dx1_r[AW:0];
      dys2_r  <= dy1_r[AW:0];
      wx2_r   <= wx1_r;
      wy2_r   <= wy1_r;
      rs2_r   <= rs1_r;
      m1_2_r  <= m1_1_r;
      m2_2_r  <= m2_1_r;
      ms2_r   <= ms1_r;
      vel2_r  <= vel1_r;
    end
  end

  // Stage 3: squares and the two dot product terms. The offsets are only
  // meaningful while the box test passes, which is all that is needed.
  logic [SQW-1:0]       xx3_r, yy3_r, rr3_r;
  logic signed [PW-1:0] px3_r, py3_r;
  logic                 near3_r, dxn3_r, dyn3_r;
  logic [AW-1:0]        ax3_r, ay3_r;
  logic [MW-1:0]        m1_3_r, m2_3_r;
  logic [MSW-1:0]       ms3_r;
  vel_t                 vel3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      xx3_r   <= ax2_r * ax2_r;
      yy3_r   <= ay2_r * ay2_r;
      rr3_r   <= rs2_r * rs2_r;
      px3_r   <= wx2_r * dxs2_r;
      py3_r   <= wy2_r * dys2_r;
      near3_r <= near2_r;
      dxn3_r  <= dxn2_r;
      dyn3_r  <= dyn2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      m1_3_r  <= m1_2_r;
      m2_3_r  <= m2_2_r;
      ms3_r   <= ms2_r;
      vel3_r  <= vel2_r;
    end
  end

  // Stage 4: squared distance, contact decision and dot product.
  logic [DDW-1:0]       dd_nxt, dd4_r;
  logic                 ct4_r, dxn4_r, dyn4_r;
  logic signed [SW-1:0] s4_r;
  logic [AW-1:0]        ax4_r, ay4_r;
  logic [MW-1:0]        m1_4_r, m2_4_r;
  logic [MSW-1:0]       ms4_r;
  vel_t                 vel4_r;

  assign dd_nxt = DDW'(xx3_r) + DDW'(yy3_r);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      dd4_r  <= dd_nxt;
      ct4_r  <= near3_r && (dd_nxt <= DDW'(rr3_r));
      s4_r   <= SW'(px3_r) + SW'(py3_r);
      dxn4_r <= dxn3_r;
      dyn4_r <= dyn3_r;
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      m1_4_r <= m1_3_r;
      m2_4_r <= m2_3_r;
      ms4_r  <= ms3_r;
      vel4_r <= vel3_r;
    end
  end

  // Stage 5: divisor, magnitude of the dot product, correction signs.
  logic          sneg, posx, posy;
  side_t         side5_nxt, side5_r;
  logic [SW-1:0] as5_r;
  logic [DW-1:0] den5_r;
  logic [AW-1:0] ax5_r, ay5_r;
  logic [MW-1:0] m1_5_r, m2_5_r;

  assign sneg = s4_r[SW-1];
  assign posx = (sneg == dxn4_r);
  assign posy = (sneg == dyn4_r);

  always_comb begin
    side5_nxt.vel          = vel4_r;
    side5_nxt.contact      = ct4_r;
    side5_nxt.go           = ct4_r && (dd4_r != '0) && (ms4_r != '0);
    side5_nxt.neg[LANE_FX] = posx;
    side5_nxt.neg[LANE_SX] = !posx;
    side5_nxt.neg[LANE_FY] = posy;
    side5_nxt.neg[LANE_SY] = !posy;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      as5_r   <= sneg ? SW'(-s4_r) : SW'(s4_r);
      den5_r  <= dd4_r * ms4_r;
      side5_r <= side5_nxt;
      ax5_r   <= ax4_r;
      ay5_r   <= ay4_r;
      m1_5_r  <= m1_4_r;
      m2_5_r  <= m2_4_r;
    end
  end

  // Stage 6: partial products of |s| times each offset.
  logic [LOW+AW-1:0]    pxl6_r, pyl6_r;
  logic [SW-LOW+AW-1:0] pxh6_r, pyh6_r;
  logic [DW-1:0]        den6_r;
  side_t                side6_r;
  logic [MW-1:0]        m1_6_r, m2_6_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pxl6_r  <= as5_r[LOW-1:0] * ax5_r;
      pyl6_r  <= as5_r[LOW-1:0] * ay5_r;
      pxh6_r  <= as5_r[SW-1:LOW] * ax5_r;
      pyh6_r  <= as5_r[SW-1:LOW] * ay5_r;
      den6_r  <= den5_r;
      side6_r <= side5_r;
      m1_6_r  <= m1_5_r;
      m2_6_r  <= m2_5_r;
    end
  end

  // Stage 7: combine the partial products.
  logic [MGW-1:0] mgx7_r, mgy7_r;
  logic [DW-1:0]  den7_r;
  side_t          side7_r;
  logic [MW-1:0]  m1_7_r, m2_7_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      mgx7_r  <= {pxh6_r, {LOW{1'b0}}} + MGW'(pxl6_r);
      mgy7_r  <= {pyh6_r, {LOW{1'b0}}} + MGW'(pyl6_r);
      den7_r  <= den6_r;
      side7_r <= side6_r;
      m1_7_r  <= m1_6_r;
      m2_7_r  <= m2_6_r;
    end
  end

  // Stage 8: partial products with the other disk's mass, per lane.
  logic [NLANES-1:0][MGW-1:0]        lmag;
  logic [NLANES-1:0][MW-1:0]         lmass;
  logic [NLANES-1:0][LOW+MW-1:0]     pl8_r;
  logic [NLANES-1:0][MGW-LOW+MW-1:0] ph8_r;
  logic [DW-1:0]                     den8_r;
  side_t                             side8_r;

  always_comb begin
    lmag[LANE_FX]  = mgx7_r;
    lmag[LANE_SX]  = mgx7_r;
    lmag[LANE_FY]  = mgy7_r;
    lmag[LANE_SY]  = mgy7_r;
    lmass[LANE_FX] = m2_7_r;
    lmass[LANE_SX] = m1_7_r;
    lmass[LANE_FY] = m2_7_r;
    lmass[LANE_SY] = m1_7_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int l = 0; l < NLANES; l++) begin
        pl8_r[l] <= lmag[l][LOW-1:0] * lmass[l];
        ph8_r[l] <= lmag[l][MGW-1:LOW] * lmass[l];
      end
      den8_r  <= den7_r;
      side8_r <= side7_r;
    end
  end

  // Stage 9: dividends (with the factor two) and the divider's first remainder.
  logic [NLANES-1:0][NW-2:0] nsum;
  logic [NLANES-1:0][NW-1:0] num;
  quo_t                      out_nxt, out_r;

  always_comb begin
    out_nxt.den  = den8_r;
    out_nxt.side = side8_r;
    for (int l = 0; l < NLANES; l++) begin
      nsum[l]        = {ph8_r[l], {LOW{1'b0}}} + (NW-1)'(pl8_r[l]);
      num[l]         = {nsum[l], 1'b0};
      out_nxt.rem[l] = DW'(num[l][NW-1:QW]);
      out_nxt.lq[l]  = num[l][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      out_r <= out_nxt;
    end
  end

  assign dn_data = out_r;

endmodule

### hdl/edpc_div_stage.sv
// One restoring division step for all four lanes, one quotient bit each.
`timescale 1ns / 1ps
module edpc_div_stage
  import edpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  output logic up_rdy,
  input  quo_t up_data,
  output logic dn_vld,
  input  logic dn_rdy,
  output quo_t dn_data
);

  logic                      vld_r;
  quo_t                      data_r, data_nxt;
  logic [NLANES-1:0][DW:0]   trial;
  logic [NLANES-1:0]         ge;

  assign up_rdy = !vld_r || dn_rdy;

  // The quotient bit shifts in where the next dividend bit shifts out.
  always_comb begin
    data_nxt = up_data;
    for (int l = 0; l < NLANES; l++) begin
      trial[l]           = {up_data.rem[l], up_data.lq[l][QW-1]};
      ge[l]              = (trial[l] >= {1'b0, up_data.den});
      data_nxt.rem[l]    = ge[l] ? DW'(trial[l] - {1'b0, up_data.den}) : DW'(trial[l]);
      data_nxt.lq[l]     = {up_data.lq[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;

endmodule

### hdl/edpc_back.sv
// Back pipeline: rounding, signed correction, saturation and the output register.
`timescale 1ns / 1ps
module edpc_back
  import edpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  output logic up_rdy,
  input  quo_t up_data,
  output logic dn_vld,
  input  logic dn_rdy,
  output res_t dn_data
);

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] v,
                                                   input logic [QW:0] q,
                                                   input logic neg);
    logic signed [SUMW-1:0] qs;
    logic signed [SUMW-1:0] sum;
    logic signed [SUMW-1:0] clip;
    qs   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum  = SUMW'(v) + qs;
    clip = (sum > SUM_MAX) ? SUM_MAX : ((sum < SUM_MIN) ? SUM_MIN : sum);
    return clip[VW-1:0];
  endfunction

  logic [BACK_STAGES-1:0] vld_r;
  logic [BACK_STAGES:0]   rdy;

  always_comb begin
    rdy[BACK_STAGES] = dn_rdy;
    for (int i = BACK_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign up_rdy = rdy[0];
  assign dn_vld = vld_r[BACK_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= up_vld;
      end
      if (rdy[1]) begin
        vld_r[1] <= vld_r[0];
      end
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  rnd_t rnd_nxt, rnd_r;

  always_comb begin
    rnd_nxt.side = up_data.side;
    for (int l = 0; l < NLANES; l++) begin
      rnd_nxt.q[l] = (QW+1)'(up_data.lq[l])
                   + (QW+1)'({up_data.rem[l], 1'b0} >= {1'b0, up_data.den});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rnd_r <= rnd_nxt;
    end
  end

  res_t res_nxt, res_r;

  always_comb begin
    res_nxt.contact = rnd_r.side.contact;
    res_nxt.vel     = rnd_r.side.vel;
    if (rnd_r.side.go) begin
      res_nxt.vel.v1x = sat_add(rnd_r.side.vel.v1x, rnd_r.q[LANE_FX], rnd_r.side.neg[LANE_FX]);
      res_nxt.vel.v2x = sat_add(rnd_r.side.vel.v2x, rnd_r.q[LANE_SX], rnd_r.side.neg[LANE_SX]);
      res_nxt.vel.v1y = sat_add(rnd_r.side.vel.v1y, rnd_r.q[LANE_FY], rnd_r.side.neg[LANE_FY]);
      res_nxt.vel.v2y = sat_add(rnd_r.side.vel.v2y, rnd_r.q[LANE_SY], rnd_r.side.neg[LANE_SY]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      res_r <= res_nxt;
    end
  end

  assign dn_data = res_r;

endmodule
